@@ rtl/core/assert_macros.svh @@
// assertion macros for the grain voice rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define GGV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define GGV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define GGV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ggv_pkg.sv @@
// types and constants of the grain voice
package ggv_pkg;

  typedef enum logic [2:0] {
    REQ_SRC_WR = 3'd0,
    REQ_WIN_WR = 3'd1,
    REQ_WGT_WR = 3'd2,
    REQ_START  = 3'd3,
    REQ_TICK   = 3'd4
  } ggv_req_e;

  localparam logic [1:0] CFG_NUM_CH  = 2'd0;
  localparam logic [1:0] CFG_BUF_LEN = 2'd1;
  localparam logic [1:0] CFG_WIN_LEN = 2'd2;

  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 24;
  localparam int BUF_LEN_W = 21;
  localparam int WIN_M1_W  = 16;
  localparam int MONO_W    = 25;

  typedef struct packed {
    logic                  src_we;
    logic                  win_we;
    logic                  wgt_we;
    logic [15:0]           addr;
    logic signed [23:0]    left;
    logic signed [23:0]    right;
    logic signed [17:0]    coef;
  } ggv_wr_t;

  typedef struct packed {
    logic [31:0]           start;
    logic [23:0]           pitch;
    logic [23:0]           len;
    logic [23:0]           idx;
    logic                  side;
    logic [BUF_LEN_W-1:0]  buf_len;
    logic [WIN_M1_W-1:0]   win_m1;
  } ggv_mono_cmd_t;

  typedef struct packed {
    logic signed [MONO_W-1:0] mono;
    logic [15:0]              gain;
    logic                     active;
    logic [6:0]               num;
  } ggv_chan_cmd_t;

endpackage

@@ rtl/core/granular_grain_voice_top.sv @@
// Grain voice: memory writes, grain start and tick items. Writes and starts leave the
// input free. For a tick with a playing grain, two 56-step iterative divisions (source
// wrap and window position) dominate the time to its first result, plus the source and
// window memory reads and the interpolation multiplies. Each channel then goes through
// weight memory read, gain scale, partial products, and round and saturate. A tick
// holds the input until its last channel result is taken into the output register,
// also when silent, and output stalls lengthen it.
`include "assert_macros.svh"
module granular_grain_voice_top #(
  parameter int BUF_DEPTH    = 65536,
  parameter int WIN_DEPTH    = 4096,
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_GRAIN    = 16777215
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic [15:0]        addr_i,
  input  logic signed [23:0] sample_left_i,
  input  logic signed [23:0] sample_right_i,
  input  logic signed [17:0] coef_value_i,
  input  logic [31:0]        start_position_i,
  input  logic [23:0]        pitch_factor_i,
  input  logic [23:0]        grain_length_i,
  input  logic [11:0]        start_delay_i,
  input  logic               seed_left_i,
  input  logic [15:0]        gain_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         channel_o,
  output logic signed [23:0] out_sample_o,
  output logic               grain_active_o,
  output logic               last_o
);
  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_MONO = 3'b010,
    T_CHAN = 3'b100
  } top_state_e;

  top_state_e state_q;

  logic [6:0]  num_ch_q, n_eff;
  logic [16:0] buf_len_q;
  logic [12:0] win_len_q;
  logic [ggv_pkg::BUF_LEN_W-1:0] buf_eff;
  logic [ggv_pkg::WIN_M1_W-1:0]  win_m1;

  logic        active_q, side_q, act_after_q;
  logic [23:0] idx_q, pitch_q, len_q, mono_idx_q;
  logic [11:0] delay_q;
  logic [31:0] start_q;
  logic [15:0] gain_q;
  logic        mono_go_q, chan_go_q;
  logic signed [ggv_pkg::MONO_W-1:0] chan_mono_q;

  logic accept, is_tick;
  logic mono_done, chan_done;
  logic signed [ggv_pkg::MONO_W-1:0] mono_val;
  logic [23:0] idx_inc;

  ggv_pkg::ggv_wr_t       wr;
  ggv_pkg::ggv_mono_cmd_t mono_cmd;
  ggv_pkg::ggv_chan_cmd_t chan_cmd;

  assign in_stall_o  = (state_q != T_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign is_tick     = (req_type_i == ggv_pkg::REQ_TICK);
  assign idx_inc     = idx_q + 24'd1;

  always_comb begin
    if (num_ch_q == 7'd0) begin
      n_eff = 7'd1;
    end else if (int'(num_ch_q) > MAX_CHANNELS) begin
      n_eff = 7'(MAX_CHANNELS);
    end else begin
      n_eff = num_ch_q;
    end
    if (buf_len_q < 17'd2) begin
      buf_eff = ggv_pkg::BUF_LEN_W'(2);
    end else if (int'(buf_len_q) > BUF_DEPTH) begin
      buf_eff = ggv_pkg::BUF_LEN_W'(BUF_DEPTH);
    end else begin
      buf_eff = ggv_pkg::BUF_LEN_W'(buf_len_q);
    end
    if (win_len_q < 13'd2) begin
      win_m1 = ggv_pkg::WIN_M1_W'(1);
    end else if (int'(win_len_q) > WIN_DEPTH) begin
      win_m1 = ggv_pkg::WIN_M1_W'(WIN_DEPTH - 1);
    end else begin
      win_m1 = ggv_pkg::WIN_M1_W'(win_len_q - 13'd1);
    end
  end

  always_comb begin
    wr.src_we = accept && (req_type_i == ggv_pkg::REQ_SRC_WR);
    wr.win_we = accept && (req_type_i == ggv_pkg::REQ_WIN_WR);
    wr.wgt_we = accept && (req_type_i == ggv_pkg::REQ_WGT_WR);
    wr.addr   = addr_i;
    wr.left   = sample_left_i;
    wr.right  = sample_right_i;
    wr.coef   = coef_value_i;
    mono_cmd.start   = start_q;
    mono_cmd.pitch   = pitch_q;
    mono_cmd.len     = len_q;
    mono_cmd.idx     = mono_idx_q;
    mono_cmd.side    = side_q;
    mono_cmd.buf_len = buf_eff;
    mono_cmd.win_m1  = win_m1;
    chan_cmd.mono    = chan_mono_q;
    chan_cmd.gain    = gain_q;
    chan_cmd.active  = act_after_q;
    chan_cmd.num     = n_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ch_q  <= 7'd4;
      buf_len_q <= 17'd65536;
      win_len_q <= 13'd4096;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ggv_pkg::CFG_NUM_CH:  num_ch_q  <= cfg_data_i[6:0];
        ggv_pkg::CFG_BUF_LEN: buf_len_q <= cfg_data_i;
        ggv_pkg::CFG_WIN_LEN: win_len_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      active_q    <= 1'b0;
      idx_q       <= '0;
      delay_q     <= '0;
      start_q     <= '0;
      pitch_q     <= '0;
      len_q       <= '0;
      side_q      <= 1'b0;
      gain_q      <= '0;
      act_after_q <= 1'b0;
      mono_go_q   <= 1'b0;
      chan_go_q   <= 1'b0;
      mono_idx_q  <= '0;
      chan_mono_q <= '0;
    end else begin
      mono_go_q <= 1'b0;
      chan_go_q <= 1'b0;
      case (state_q)
        T_IDLE: begin
          if (accept && req_type_i == ggv_pkg::REQ_START) begin
            start_q  <= start_position_i;
            pitch_q  <= pitch_factor_i;
            len_q    <= (32'(grain_length_i) > 32'(MAX_GRAIN)) ? 24'(MAX_GRAIN)
                                                             : grain_length_i;
            delay_q  <= start_delay_i;
            side_q   <= seed_left_i;
            gain_q   <= gain_i;
            idx_q    <= '0;
            active_q <= 1'b1;
          end else if (accept && is_tick) begin
            chan_mono_q <= '0;
            if (active_q && delay_q != 12'd0) begin
              delay_q     <= delay_q - 12'd1;
              act_after_q <= 1'b1;
              chan_go_q   <= 1'b1;
              state_q     <= T_CHAN;
            end else if (active_q && idx_q < len_q) begin
              mono_idx_q  <= idx_q;
              idx_q       <= idx_inc;
              act_after_q <= (idx_inc < len_q);
              active_q    <= (idx_inc < len_q);
              mono_go_q   <= 1'b1;
              state_q     <= T_MONO;
            end else begin
              active_q    <= 1'b0;
              act_after_q <= 1'b0;
              chan_go_q   <= 1'b1;
              state_q     <= T_CHAN;
            end
          end
        end
        T_MONO: begin
          if (mono_done) begin
            chan_mono_q <= mono_val;
            chan_go_q   <= 1'b1;
            state_q     <= T_CHAN;
          end
        end
        T_CHAN: if (chan_done) state_q <= T_IDLE;
        default: state_q <= T_IDLE;
      endcase
    end
  end

  ggv_mono #(
    .BUF_DEPTH (BUF_DEPTH),
    .WIN_DEPTH (WIN_DEPTH)
  ) u_mono (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .go_i   (mono_go_q),
    .cmd_i  (mono_cmd),
    .done_o (mono_done),
    .mono_o (mono_val)
  );

  ggv_chan #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_chan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (wr),
    .go_i           (chan_go_q),
    .cmd_i          (chan_cmd),
    .done_o         (chan_done),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .channel_o      (channel_o),
    .out_sample_o   (out_sample_o),
    .grain_active_o (grain_active_o),
    .last_o         (last_o)
  );

  `GGV_ASSERT_IMP(a_mono_done_state, mono_done, state_q == T_MONO, "engine finished outside tick")
  `GGV_ASSERT_IMP(a_chan_done_state, chan_done, state_q == T_CHAN, "channels done outside tick")
  `GGV_ASSERT_IMP(a_last_channel, out_valid_o && last_o, channel_o == 6'(n_eff - 7'd1),
    "last flag on wrong channel")
  `GGV_ASSERT_NEXT(a_idle_tick, accept && is_tick && !active_q, state_q == T_CHAN,
    "idle tick did not go straight to channel output")
endmodule

@@ rtl/core/ggv_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module ggv_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              go_i,
  input  logic [ggv_pkg::DIV_NUM_W-1:0]     num_i,
  input  logic [ggv_pkg::DIV_DEN_W-1:0]     den_i,
  output logic                              valid_o,
  output logic [ggv_pkg::DIV_NUM_W-1:0]     quot_o,
  output logic [ggv_pkg::DIV_DEN_W-1:0]     rem_o
);
  localparam int NW = ggv_pkg::DIV_NUM_W;
  localparam int DW = ggv_pkg::DIV_DEN_W;

  logic          busy_q, valid_q;
  logic [5:0]    cnt_q;
  logic [NW-1:0] num_q;
  logic [DW-1:0] rem_q, den_q;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign trial = {rem_q, num_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (go_i) begin
      busy_q  <= 1'b1;
      valid_q <= 1'b0;
      cnt_q   <= 6'(NW - 1);
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        busy_q  <= 1'b0;
        valid_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign valid_o = valid_q;
  assign quot_o  = num_q;
  assign rem_o   = rem_q;
endmodule

@@ rtl/core/ggv_mono.sv @@
// grain sample engine: source and window memories, interpolation and windowing
module ggv_mono #(
  parameter int BUF_DEPTH = 65536,
  parameter int WIN_DEPTH = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ggv_pkg::ggv_wr_t                     wr_i,
  input  logic                                 go_i,
  input  ggv_pkg::ggv_mono_cmd_t               cmd_i,
  output logic                                 done_o,
  output logic signed [ggv_pkg::MONO_W-1:0]    mono_o
);
  localparam int SAW = $clog2(BUF_DEPTH);
  localparam int WAW = $clog2(WIN_DEPTH);
  localparam int BUF_LEN_W_LOCAL = ggv_pkg::BUF_LEN_W;

  typedef enum logic [15:0] {
    M_IDLE = 16'h0001, M_ADD  = 16'h0002, M_DIV1 = 16'h0004, M_RD0  = 16'h0008,
    M_RD1  = 16'h0010, M_SI   = 16'h0020, M_SM   = 16'h0040, M_SR   = 16'h0080,
    M_WW   = 16'h0100, M_WR0  = 16'h0200, M_WR1  = 16'h0400, M_WI   = 16'h0800,
    M_WM   = 16'h1000, M_WRND = 16'h2000, M_MM   = 16'h4000, M_MR   = 16'h8000
  } mono_state_e;

  mono_state_e state_q, state_d;

  logic [47:0] src_mem [BUF_DEPTH];
  logic [16:0] win_mem [WIN_DEPTH];
  logic [47:0] src_rd_q;
  logic [16:0] win_rd_q;
  logic [SAW-1:0] src_raddr;
  logic [WAW-1:0] win_raddr;

  ggv_pkg::ggv_mono_cmd_t cmd_q;
  logic [47:0] prod_q;
  logic [39:0] wprod_q;
  logic [48:0] pos_q, posw;
  logic [SAW-1:0] i0_q, i1_q;
  logic [WAW-1:0] j0_q, j0_d;
  logic [15:0] wf_q;
  logic signed [23:0] s0_q, s_sel, s_q;
  logic signed [24:0] sdiff_q;
  logic signed [41:0] sprod_q, s_acc;
  logic [16:0] w0_q;
  logic signed [17:0] wdiff_q, w_q;
  logic signed [34:0] wprod2_q, w_acc;
  logic signed [41:0] mprod_q, m_acc;
  logic signed [ggv_pkg::MONO_W-1:0] mono_q;
  logic done_q;
  logic [BUF_LEN_W_LOCAL-1:0] i0_next;

  logic div_go, div_valid;
  logic [ggv_pkg::DIV_NUM_W-1:0] div_num, div_quot;
  logic [ggv_pkg::DIV_DEN_W-1:0] div_den, div_rem;
  logic [39:0] q_hi;

  ggv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .valid_o (div_valid),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // memories
  always_ff @(posedge clk_i) begin
    if (wr_i.src_we && ({16'd0, wr_i.addr} < 32'(BUF_DEPTH))) begin
      src_mem[SAW'(wr_i.addr)] <= {wr_i.left, wr_i.right};
    end
    src_rd_q <= src_mem[src_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.win_we && ({16'd0, wr_i.addr} < 32'(WIN_DEPTH))) begin
      if (wr_i.coef < 18'sd0) begin
        win_mem[WAW'(wr_i.addr)] <= 17'd0;
      end else if (wr_i.coef > 18'sd65536) begin
        win_mem[WAW'(wr_i.addr)] <= 17'd65536;
      end else begin
        win_mem[WAW'(wr_i.addr)] <= wr_i.coef[16:0];
      end
    end
    win_rd_q <= win_mem[win_raddr];
  end

  assign src_raddr = (state_q == M_RD0) ? i0_q : i1_q;
  assign win_raddr = (state_q == M_WR0) ? j0_q : WAW'(j0_q + 1'b1);

  assign posw    = 49'(cmd_q.start) + 49'(prod_q);
  assign s_sel   = cmd_q.side ? $signed(src_rd_q[47:24]) : $signed(src_rd_q[23:0]);
  assign i0_next = BUF_LEN_W_LOCAL'(div_rem) + 1'b1;
  assign s_acc   = 42'($signed({s0_q, 16'h0})) + sprod_q + 42'sd32768;
  assign w_acc   = 35'($signed({1'b0, w0_q, 16'h0})) + wprod2_q + 35'sd32768;
  assign m_acc   = mprod_q + 42'sd32768;
  assign q_hi    = div_quot[55:16];
  assign j0_d    = (q_hi > 40'(WIN_DEPTH - 2)) ? WAW'(WIN_DEPTH - 2) : WAW'(q_hi);

  always_comb begin
    state_d = state_q;
    div_go  = 1'b0;
    div_num = ggv_pkg::DIV_NUM_W'(posw[48:16]);
    div_den = ggv_pkg::DIV_DEN_W'(cmd_q.buf_len);
    case (state_q)
      M_IDLE: if (go_i) state_d = M_ADD;
      M_ADD: begin
        div_go  = 1'b1;
        state_d = M_DIV1;
      end
      M_DIV1: begin
        if (div_valid) begin
          div_go  = 1'b1;
          div_num = {wprod_q, 16'h0};
          div_den = cmd_q.len;
          state_d = M_RD0;
        end
      end
      M_RD0:  state_d = M_RD1;
      M_RD1:  state_d = M_SI;
      M_SI:   state_d = M_SM;
      M_SM:   state_d = M_SR;
      M_SR:   state_d = M_WW;
      M_WW:   if (div_valid) state_d = M_WR0;
      M_WR0:  state_d = M_WR1;
      M_WR1:  state_d = M_WI;
      M_WI:   state_d = M_WM;
      M_WM:   state_d = M_WRND;
      M_WRND: state_d = M_MM;
      M_MM:   state_d = M_MR;
      M_MR:   state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == M_MR);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        if (go_i) begin
          cmd_q   <= cmd_i;
          prod_q  <= cmd_i.idx * cmd_i.pitch;
          wprod_q <= cmd_i.idx * cmd_i.win_m1;
        end
      end
      M_ADD: pos_q <= posw;
      M_DIV1: begin
        if (div_valid) begin
          i0_q <= SAW'(div_rem);
          i1_q <= (i0_next == cmd_q.buf_len) ? '0 : SAW'(i0_next);
        end
      end
      M_RD1: s0_q    <= s_sel;
      M_SI:  sdiff_q <= 25'(s_sel) - 25'(s0_q);
      M_SM:  sprod_q <= sdiff_q * $signed({1'b0, pos_q[15:0]});
      M_SR:  s_q     <= s_acc[39:16];
      M_WW: begin
        if (div_valid) begin
          j0_q <= j0_d;
          wf_q <= div_quot[15:0];
        end
      end
      M_WR1:  w0_q     <= win_rd_q;
      M_WI:   wdiff_q  <= $signed({1'b0, win_rd_q}) - $signed({1'b0, w0_q});
      M_WM:   wprod2_q <= wdiff_q * $signed({1'b0, wf_q});
      M_WRND: w_q      <= w_acc[33:16];
      M_MM:   mprod_q  <= s_q * w_q;
      M_MR:   mono_q   <= m_acc[40:16];
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign mono_o = mono_q;
endmodule

@@ rtl/core/ggv_chan.sv @@
// per-channel weighting, rounding, saturation and result register
module ggv_chan #(
  parameter int MAX_CHANNELS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ggv_pkg::ggv_wr_t       wr_i,
  input  logic                   go_i,
  input  ggv_pkg::ggv_chan_cmd_t cmd_i,
  output logic                   done_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [5:0]             channel_o,
  output logic signed [23:0]     out_sample_o,
  output logic                   grain_active_o,
  output logic                   last_o
);
  localparam int CAW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_RD   = 5'b00010,
    C_SC   = 5'b00100,
    C_PP   = 5'b01000,
    C_OUT  = 5'b10000
  } chan_state_e;

  chan_state_e state_q;

  logic signed [15:0] wgt_mem [MAX_CHANNELS];
  logic signed [15:0] rd_q;
  ggv_pkg::ggv_chan_cmd_t cmd_q;
  logic [6:0] ch_q;
  logic signed [32:0] scale_q;
  logic signed [41:0] plo_q, phi_q;
  logic signed [59:0] tot, v;
  logic [23:0] v_sat;
  logic is_last, load;

  logic out_valid_q, last_q, act_q;
  logic [5:0] channel_q;
  logic [23:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.wgt_we && ({16'd0, wr_i.addr} < 32'(MAX_CHANNELS))) begin
      if (wr_i.coef < -18'sd32768) begin
        wgt_mem[CAW'(wr_i.addr)] <= -16'sd32768;
      end else if (wr_i.coef > 18'sd32767) begin
        wgt_mem[CAW'(wr_i.addr)] <= 16'sd32767;
      end else begin
        wgt_mem[CAW'(wr_i.addr)] <= wr_i.coef[15:0];
      end
    end
    rd_q <= wgt_mem[CAW'(ch_q)];
  end

  assign tot = (60'(phi_q) <<< 16) + 60'(plo_q) + 60'sd33554432;
  assign v   = tot >>> 26;
  always_comb begin
    if (v > 60'sd8388607) begin
      v_sat = 24'h7fffff;
    end else if (v < -60'sd8388608) begin
      v_sat = 24'h800000;
    end else begin
      v_sat = v[23:0];
    end
  end

  assign is_last = (ch_q == cmd_q.num - 7'd1);
  assign load    = (state_q == C_OUT) && (!out_valid_q || !out_stall_i);
  assign done_o  = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        C_IDLE: begin
          if (go_i) begin
            ch_q    <= '0;
            state_q <= C_RD;
          end
        end
        C_RD: state_q <= C_SC;
        C_SC: state_q <= C_PP;
        C_PP: state_q <= C_OUT;
        C_OUT: begin
          if (load) begin
            if (is_last) begin
              state_q <= C_IDLE;
            end else begin
              ch_q    <= ch_q + 7'd1;
              state_q <= C_RD;
            end
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i && state_q == C_IDLE) begin
      cmd_q <= cmd_i;
    end
    scale_q <= rd_q * $signed({1'b0, cmd_q.gain});
    plo_q   <= cmd_q.mono * $signed({1'b0, scale_q[15:0]});
    phi_q   <= cmd_q.mono * $signed(scale_q[32:16]);
    if (load) begin
      channel_q <= ch_q[5:0];
      sample_q  <= v_sat;
      act_q     <= cmd_q.active;
      last_q    <= is_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign channel_o      = channel_q;
  assign out_sample_o   = sample_q;
  assign grain_active_o = act_q;
  assign last_o         = last_q;
endmodule
